// ----- hdl/sha1s_pkg.sv -----
// shared types and constants for the sha-1 stream hasher
package sha1s_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_vld;
    logic       eom;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_FINAL, ST_OUT
  } bstate_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20) return K0;
    else if (t < 7'd40) return K1;
    else if (t < 7'd60) return K2;
    else return K3;
  endfunction

endpackage

// ----- hdl/sha1s_front.sv -----
// input front: accepts items into a short queue
module sha1s_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_byte_valid,
  input  logic             in_end_of_message,
  output logic             q_valid,
  output sha1s_pkg::item_t q_item,
  input  logic             q_pop
);
  import sha1s_pkg::*;

  item_t mem_r [QDEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic push, pop;

  assign in_stall = (cnt_r == 3'(QDEPTH));
  // items with nothing to do are dropped here
  assign push = in_valid && !in_stall && (in_byte_valid || in_end_of_message);
  assign q_valid = (cnt_r != 3'd0);
  assign pop = q_pop && q_valid;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{in_data_byte, in_byte_valid, in_end_of_message};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(QDEPTH))
    else $error("queue count overflow");
  a_noover: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'(QDEPTH) && !pop) |=> cnt_r == 3'(QDEPTH))
    else $error("full queue lost entry");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 && !push) |=> !q_valid)
    else $error("empty queue shows valid");
endmodule

// ----- hdl/sha1s_core.sv -----
// back end: block packing, padding, 80-round compression, digest output
module sha1s_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  sha1s_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1s_pkg::*;

  bstate_t st_r, st_nxt, ret_r, ret_nxt;
  logic [31:0] h_r [5];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [5:0] cnt_r;
  logic [63:0] len_r;
  logic [6:0] t_r;
  logic [2:0] idx_r;
  logic [2:0] lbyte_r;

  logic put;
  logic [7:0] pbyte;
  logic [31:0] wt, f, tmp, wsched;

  always_comb begin
    wsched = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wt = (t_r < 7'd16) ? w_r[0] : {wsched[30:0], wsched[31]};
    if (t_r < 7'd20) f = (b_r & c_r) | (~b_r & d_r);
    else if (t_r < 7'd40) f = b_r ^ c_r ^ d_r;
    else if (t_r < 7'd60) f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
    else f = b_r ^ c_r ^ d_r;
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + round_k(t_r) + wt;
  end

  always_comb begin
    st_nxt = st_r;
    ret_nxt = ret_r;
    q_pop = 1'b0;
    put = 1'b0;
    pbyte = q_item.data;
    unique case (st_r)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        put = q_item.byte_vld;
        ret_nxt = q_item.eom ? ST_PAD : ST_IDLE;
        if (q_item.byte_vld && cnt_r == 6'd63) st_nxt = ST_ROUND;
        else if (q_item.eom) st_nxt = ST_PAD;
      end
      ST_PAD: begin
        // first pad byte after the message is 0x80, rest zero
        put = 1'b1;
        pbyte = ret_r == ST_PAD ? PAD_BYTE : 8'h00;
        ret_nxt = ST_LEN;
        if (cnt_r == 6'd63) st_nxt = ST_ROUND;
        else if (cnt_r == 6'd55) st_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (cnt_r < 6'd56) begin
          put = 1'b1; pbyte = 8'h00; ret_nxt = ST_LEN;
          if (cnt_r == 6'd63) st_nxt = ST_ROUND;
        end else begin
          put = 1'b1;
          pbyte = len_r[8*(7-lbyte_r) +: 8];
          ret_nxt = ST_OUT;
          if (cnt_r == 6'd63) st_nxt = ST_ROUND;
        end
      end
      ST_ROUND: if (t_r == 7'd79) st_nxt = ST_FINAL;
      ST_FINAL: begin
        if (ret_r == ST_IDLE) st_nxt = ST_IDLE;
        else if (ret_r == ST_PAD) st_nxt = ST_PAD;
        else if (ret_r == ST_LEN) st_nxt = ST_LEN;
        else st_nxt = ST_OUT;
      end
      ST_OUT: if (!out_stall && idx_r == 3'd4) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // ST_PAD entered from a full block with ret ST_PAD still needs the 0x80
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ret_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; len_r <= '0; t_r <= '0; idx_r <= '0; lbyte_r <= '0;
      h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3; h_r[4] <= IV4;
    end else begin
      if (put) begin
        w_r[cnt_r[5:2]] <= (cnt_r[1:0] == 2'd0) ? {pbyte, 24'h0} :
          (w_r[cnt_r[5:2]] | ({24'h0, pbyte} << (5'd24 - {cnt_r[1:0], 3'd0})));
        cnt_r <= cnt_r + 6'd1;
        if (st_r == ST_IDLE) len_r <= len_r + 64'd8;
        if (st_r == ST_LEN && cnt_r >= 6'd56) lbyte_r <= lbyte_r + 3'd1;
        if (cnt_r == 6'd63) begin
          t_r <= '0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        end
      end
      if (st_r == ST_ROUND) begin
        if (t_r >= 7'd16) begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wt;
        end else begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_r[0];
        end
        e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= tmp;
        t_r <= t_r + 7'd1;
      end
      if (st_r == ST_FINAL) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
        idx_r <= '0;
      end
      if (st_r == ST_OUT && !out_stall) begin
        idx_r <= (idx_r == 3'd4) ? 3'd0 : idx_r + 3'd1;
        if (idx_r == 3'd4) begin
          h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3; h_r[4] <= IV4;
          cnt_r <= '0; len_r <= '0; lbyte_r <= '0;
        end
      end
    end
  end

  assign out_valid = (st_r == ST_OUT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index = idx_r;
  assign out_last_word = (idx_r == 3'd4);

  a_idx: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> idx_r <= 3'd4)
    else $error("digest index out of range");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> st_r == ST_IDLE)
    else $error("pop outside idle");
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROUND && t_r == 7'd79) |=> st_r == ST_FINAL)
    else $error("round count slip");
endmodule

// ----- hdl/sha1_stream_hash.sv -----
// top level of the sha-1 stream hasher
// usage:
//   in channel: one message byte per transaction (in_data_byte, in_byte_valid),
//   in_end_of_message on the last transaction; byte_valid 0 with end of
//   message hashes whatever came before (empty message allowed).
//   out channel: five transactions per message, digest words 0..4,
//   most significant first, out_last_word on the fifth.
// throughput: the back end takes one byte a cycle from the queue while idle,
//   and each full 64-byte block then stops intake for the round loop (one
//   round a cycle) and the chaining update. padding adds one or two
//   compressions before the digest appears.
// a four-entry queue holds incoming transactions while the round loop runs.
// reset clears the queue, the length count and loads the initial chaining
//   words. a stalled result holds its word; the back end waits on it and
//   the queue keeps taking input until full.
module sha1_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1s_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  sha1s_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_byte_valid,
    .in_end_of_message, .q_valid, .q_item, .q_pop
  );

  sha1s_core u_core (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .out_valid, .out_stall,
    .out_digest_word, .out_word_index, .out_last_word
  );
endmodule

// ----- sim/sha1_stream_hash_check.sv -----
// checker for the sha-1 stream hasher: digest prediction and result compare
`timescale 1ns / 1ps
module sha1_stream_hash_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digests_seen
);
  import sha1s_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] hash_state [5];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, tmp;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16)
        w[t % 16] = rol(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
      if (t < 20) f = (b & c) | (~b & d);
      else if (t < 40) f = b ^ c ^ d;
      else if (t < 60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      tmp = rol(a, 5) + f + e + round_k(t[6:0]) + w[t % 16];
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic push_byte(input logic [7:0] x);
    logic [3:0] wi;
    wi = fill[5:2];
    if (fill[1:0] == 2'd0) blk[wi] = {x, 24'h0};
    else blk[wi] = blk[wi] | ({24'h0, x} << (24 - 8 * fill[1:0]));
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
  endtask

  task automatic restart_message();
    hash_state[0] = IV0; hash_state[1] = IV1; hash_state[2] = IV2;
    hash_state[3] = IV3; hash_state[4] = IV4;
    fill = '0;
    bit_len = '0;
  endtask

  task automatic absorb_item(input logic [7:0] x, input logic bv, input logic eom);
    logic [63:0] len;
    if (bv) begin
      push_byte(x);
      bit_len += 64'd8;
    end
    if (eom) begin
      len = bit_len;
      push_byte(PAD_BYTE);
      while (fill != 6'd56) push_byte(8'h00);
      for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
      for (int i = 0; i < 5; i++)
        digest_q.insert(digest_q.size(), digest_word_t'{hash_state[i], i[2:0], i == 4});
      restart_message();
    end
  endtask

  digest_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      for (int i = 0; i < 16; i++) blk[i] = '0;
      digest_q.delete();
      fail_count <= 0;
      digests_seen <= 0;
    end else begin
      if (in_valid && !in_stall)
        absorb_item(in_data_byte, in_byte_valid, in_end_of_message);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected result word %h idx %0d last %0b", $time,
                   out_digest_word, out_word_index, out_last_word);
          fail_count <= fail_count + 1;
        end else begin
          want = digest_q.pop_front();
          if (want.word !== out_digest_word || want.idx !== out_word_index ||
              want.last !== out_last_word) begin
            $display("%0t: mismatch expected word %h idx %0d last %0b, got %h %0d %0b",
                     $time, want.word, want.idx, want.last,
                     out_digest_word, out_word_index, out_last_word);
            fail_count <= fail_count + 1;
          end
          if (want.last) digests_seen <= digests_seen + 1;
        end
      end
    end
    pending_words = digest_q.size();
  end

endmodule

// ----- sim/sha1_stream_hash_test.sv -----
// top of the sha-1 stream hasher testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module sha1_stream_hash_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count, pending_words, digests_seen;
  int          cycle_count = 0;
  int          msg_count = 0;
  int          byte_count = 0;
  int          item_count = 0;
  int          rx_wait = 0;
  bit          hold_off = 1'b0;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 230;

  always #5 clk = ~clk;

  sha1_stream_hash i_dut (.*);

  sha1_stream_hash_check i_check (.*);

  // one transaction offered, held until accepted, then a random gap unless no_gap is set
  task automatic send(input logic [7:0] x, input logic bv, input logic eom,
                      input bit no_gap = 0);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= x;
    in_byte_valid <= bv;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
    if (bv) byte_count++;
    if (eom) msg_count++;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit tail_flag);
    for (int i = 0; i < len; i++)
      send(8'($urandom_range(0, 255)), 1'b1, tail_flag && i == len - 1);
    if (!tail_flag || len == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // receiver stalls: a drawn wait per transaction, or long while hold_off is set
  always @(posedge clk) begin
    int w;
    if (hold_off) begin
      out_stall <= 1'b1;
      rx_wait <= 0;
    end else if (out_stall) begin
      if (rx_wait <= 1) out_stall <= 1'b0;
      else rx_wait <= rx_wait - 1;
    end else if (out_valid) begin
      w = $urandom_range(0, 11);
      out_stall <= (w > 0);
      rx_wait <= w;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, "abc", extremes, pad boundaries
    send(8'hff, 1'b0, 1'b1);
    send(8'h61, 1'b1, 1'b0); send(8'h62, 1'b1, 1'b0); send(8'h63, 1'b1, 1'b1);
    send(8'h00, 1'b1, 1'b0); send(8'h5a, 1'b0, 1'b0); send(8'hff, 1'b1, 1'b0);
    send(8'ha5, 1'b0, 1'b1);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b1);
    send_message(55, 1);
    send_message(56, 0);
    send_message(64, 1);
    // long receiver hold-off while the sender keeps offering bytes
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int m = 0; m < 3; m++)
          for (int i = 0; i < 4; i++) send(8'($urandom_range(0, 255)), 1'b1, i == 3, 1);
      end
    join
    // random: mostly short messages, a few long ones, some idle bytes
    while (item_count < ITEM_TARGET) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
      if (len > ITEM_TARGET - item_count) len = ITEM_TARGET - item_count;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d transactions in %0d messages with %0d bytes, %0d digests checked",
             item_count, msg_count, byte_count, digests_seen);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
